/* rtl/core/svfl_pkg.sv */
// Package for the limited state variable filter.
// Holds register indexes, widths, constants and the sequencer state type.
// No dependencies.
package svfl_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_FIXED_FREQ = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CENTER_FREQ = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OCTAVE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DAMPING = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ATTACK = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RELEASE = 3'd5;

    localparam int EnvPeriod = 8;
    localparam int WinW = $clog2(EnvPeriod + 1);
    localparam logic [WinW-1:0] WinEnd = WinW'(EnvPeriod);

    localparam logic [31:0] DampReset = 32'd1073741824;
    localparam logic signed [31:0] ExpOffset = 32'sd134217728;
    localparam logic signed [31:0] ExpScale = 32'sd715827883;
    localparam logic signed [31:0] ExpBias = 32'sd715827882;
    localparam logic signed [31:0] FreqClamp = 32'sd5378279;
    localparam logic [26:0] FracMask = 27'h7FFFFFF;
    localparam logic [30:0] EnvThresh = 31'd131072000;
    localparam logic [22:0] GainNum = 23'd8192000;
    localparam logic [12:0] UnityGain = 13'd4096;

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CTRL  = 11'b00000000010,
        ST_MUL   = 11'b00000000100,
        ST_LP    = 11'b00000001000,
        ST_HP    = 11'b00000010000,
        ST_BP    = 11'b00000100000,
        ST_OUT   = 11'b00001000000,
        ST_ENV   = 11'b00010000000,
        ST_DIV   = 11'b00100000000,
        ST_DONE  = 11'b01000000000,
        ST_EXP   = 11'b10000000000
    } t_state;

endpackage

/* rtl/core/svfl_if.sv */
// Valid/ready channel interfaces for the limited state variable filter.
// Depends on svfl_pkg.
interface svfl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;
    logic signed [15:0] ctrl_sample;
    logic               ctrl_present;
    modport source (output valid, sample_in, ctrl_sample, ctrl_present, input ready);
    modport sink (input valid, sample_in, ctrl_sample, ctrl_present, output ready);
endinterface

interface svfl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] low_out;
    logic signed [15:0] band_out;
    logic signed [15:0] high_out;
    modport source (output valid, low_out, band_out, high_out, input ready);
    modport sink (input valid, low_out, band_out, high_out, output ready);
endinterface

interface svfl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [svfl_pkg::CfgIdxW-1:0]  index;
    logic [svfl_pkg::CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/state_variable_filter_limited_top.sv */
// Top level of the two-times oversampled limited state variable filter.
// Depends on svfl_pkg and the channel interfaces in svfl_if.sv.
//
// Usage:
//   i_in carries one sample transaction (sample_in, ctrl_sample,
//   ctrl_present). o_out returns one transaction with saturated lowpass,
//   bandpass and highpass samples per input. i_cfg writes the six
//   configuration registers by index; it is always ready.
//   All products come from one shared 32x32 signed multiplier under a
//   small sequencer, each product registered before use.
//   Fixed mode: the input is scaled, then the lowpass, highpass and
//   bandpass steps run twice before the output register is loaded.
//   Control mode first adds the exponential cutoff (4 products). At the
//   end of each envelope window the envelope update follows and, with the
//   limiter engaged, a bit-serial 23-bit gain division and a gain load step.
//   i_in is ready only while the sequencer is idle; the result sits in an
//   output register until taken, and a new transaction is accepted in that
//   time, its result waiting for the register to empty.
//   Synchronous active-low reset clears filter state, the envelope and
//   sets unity gain and the damping default.
module state_variable_filter_limited_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    svfl_in_if.sink      i_in,
    svfl_out_if.source   o_out,
    svfl_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [30:0] r_fixed_freq, r_center_freq, r_damping;
    logic [14:0] r_octave;
    logic [15:0] r_attack, r_release;

    // filter and limiter state
    logic signed [31:0]        r_prev, r_low, r_band;
    logic [15:0]               r_peak;
    logic [svfl_pkg::WinW-1:0] r_win;
    logic [30:0]               r_env;
    logic [12:0]               r_gain;

    // per-sample work registers
    svfl_pkg::t_state   r_state;
    logic [3:0]         r_step;
    logic signed [15:0] r_s, r_ctl;
    logic               r_mode;
    logic signed [31:0] r_fm, r_x, r_lp, r_bp, r_hp, r_lp1, r_bp1, r_hp1, r_t;
    logic signed [31:0] r_ctrlv;
    logic signed [63:0] r_prod;
    logic [22:0]        r_rem;
    logic [22:0]        r_quo;
    logic [4:0]         r_dcnt;
    logic [14:0]        r_div;

    // output register
    logic               r_ovalid;
    logic signed [15:0] r_lo, r_bo, r_ho;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // rounded high word of the registered product
    logic signed [63:0] rnd_p;
    logic signed [31:0] rmul_q, fmul_q;
    assign rnd_p = r_prod + 64'sh80000000;
    assign rmul_q = rnd_p[63:32];
    assign fmul_q = {rmul_q[29:0], 2'b00};

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [18:0] t;
        t = v[31:13];
        if (t > 19'sd32767) return 16'sh7FFF;
        if (t < -19'sd32768) return -16'sh8000;
        return t[15:0];
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : v;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == svfl_pkg::ST_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.low_out  = r_lo;
    assign o_out.band_out = r_bo;
    assign o_out.high_out = r_ho;

    // multiplier operand selection per state/step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            svfl_pkg::ST_CTRL: begin
                mul_a = 32'(r_ctl);
                mul_b = 32'({17'd0, r_octave});
            end
            svfl_pkg::ST_EXP: begin
                mul_a = r_t;
                mul_b = (r_step == 4'd0) ? r_t :
                        (r_step == 4'd1) ? svfl_pkg::ExpScale : 32'({1'b0, r_center_freq});
            end
            svfl_pkg::ST_MUL: begin
                mul_a = 32'(r_s);
                mul_b = r_mode ? 32'({19'd0, r_gain}) : 32'sd4096;
            end
            svfl_pkg::ST_LP: begin
                mul_a = r_fm;
                mul_b = (r_step == 4'd0) ? r_band : r_bp;
            end
            svfl_pkg::ST_HP: begin
                mul_a = 32'({1'b0, r_damping});
                mul_b = (r_step == 4'd0) ? r_band : r_bp;
            end
            svfl_pkg::ST_BP: begin
                mul_a = r_fm;
                mul_b = r_hp;
            end
            svfl_pkg::ST_ENV: begin
                mul_a = r_t;
                mul_b = 32'({16'd0, (r_step == 4'd0) ? r_attack : r_release});
            end
            default: ;
        endcase
    end

    logic signed [31:0] pk_full;
    assign pk_full = {r_peak[14:0], 16'd0} | {r_peak[15], 31'd0};

    always_ff @(posedge i_clk) begin
        logic signed [31:0] hx, ctrl_e;
        logic [15:0] m, pk;
        logic [32:0] e;
        logic [31:0] env_d;
        logic [23:0] trial;
        logic signed [31:0] sh, n, f;
        if (!i_rst_n) begin
            r_fixed_freq <= '0; r_center_freq <= '0; r_octave <= '0;
            r_damping <= svfl_pkg::DampReset[30:0]; r_attack <= '0; r_release <= '0;
            r_prev <= '0; r_low <= '0; r_band <= '0; r_peak <= '0; r_win <= '0;
            r_env <= '0; r_gain <= svfl_pkg::UnityGain;
            r_state <= svfl_pkg::ST_IDLE; r_step <= '0; r_ovalid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    svfl_pkg::REG_FIXED_FREQ:  r_fixed_freq  <= i_cfg.data[30:0];
                    svfl_pkg::REG_CENTER_FREQ: r_center_freq <= i_cfg.data[30:0];
                    svfl_pkg::REG_OCTAVE:      r_octave      <= i_cfg.data[14:0];
                    svfl_pkg::REG_DAMPING:     r_damping     <= i_cfg.data[30:0];
                    svfl_pkg::REG_ATTACK:      r_attack      <= i_cfg.data[15:0];
                    svfl_pkg::REG_RELEASE:     r_release     <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                svfl_pkg::ST_IDLE: begin
                    if (i_in.valid) begin
                        r_s <= i_in.sample_in;
                        r_ctl <= i_in.ctrl_sample;
                        r_mode <= i_in.ctrl_present;
                        r_step <= '0;
                        r_fm <= 32'({1'b0, r_fixed_freq});
                        r_state <= i_in.ctrl_present ? svfl_pkg::ST_CTRL : svfl_pkg::ST_MUL;
                    end
                end
                // control * octave, then exp polynomial start
                svfl_pkg::ST_CTRL: begin
                    if (r_step == 4'd0) begin
                        r_prod <= mul_p; r_step <= 4'd1;
                    end else begin
                        ctrl_e = r_prod[31:0];
                        r_ctrlv <= ctrl_e;
                        r_t <= 32'(({5'd0, ctrl_e[26:0] & svfl_pkg::FracMask}
                               + svfl_pkg::ExpOffset) <<< 3);
                        r_step <= '0; r_state <= svfl_pkg::ST_EXP;
                    end
                end
                // n*n, *scale, shift, *center with a register after each product
                svfl_pkg::ST_EXP: begin
                    if (r_step[3]) begin
                        unique case (r_step[2:0])
                            3'd0: r_t <= rmul_q;
                            3'd1: begin
                                n = (rmul_q <<< 3) + svfl_pkg::ExpBias;
                                sh = 32'sd6 - (r_ctrlv >>> 27);
                                if (sh < 0) sh = 0;
                                r_t <= n >>> sh[5:0];
                            end
                            default: begin
                                f = rmul_q;
                                if (f > svfl_pkg::FreqClamp) f = svfl_pkg::FreqClamp;
                                r_fm <= f <<< 8;
                                r_state <= svfl_pkg::ST_MUL;
                            end
                        endcase
                        r_step <= (r_step[2:0] >= 3'd2) ? 4'd0 : {1'b0, r_step[2:0] + 3'd1};
                    end else begin
                        r_prod <= mul_p;
                        r_step <= {1'b1, r_step[2:0]};
                    end
                end
                svfl_pkg::ST_MUL: begin
                    r_x <= mul_p[31:0];
                    r_step <= '0;
                    r_state <= svfl_pkg::ST_LP;
                end
                // step bit 3 marks the second half (product registered)
                svfl_pkg::ST_LP: begin
                    if (!r_step[3]) begin
                        r_prod <= mul_p; r_step <= r_step | 4'b1000;
                    end else begin
                        r_lp <= ((r_step[0]) ? r_lp : r_low) + fmul_q;
                        r_step <= r_step & 4'b0111; r_state <= svfl_pkg::ST_HP;
                    end
                end
                svfl_pkg::ST_HP: begin
                    if (!r_step[3]) begin
                        r_prod <= mul_p; r_step <= r_step | 4'b1000;
                    end else begin
                        hx = r_step[0] ? r_x : ((r_x + r_prev) >>> 1);
                        r_hp <= hx - r_lp - fmul_q;
                        r_step <= r_step & 4'b0111; r_state <= svfl_pkg::ST_BP;
                    end
                end
                svfl_pkg::ST_BP: begin
                    if (!r_step[3]) begin
                        r_prod <= mul_p; r_step <= r_step | 4'b1000;
                    end else if (!r_step[0]) begin
                        r_bp <= r_band + fmul_q;
                        r_bp1 <= r_band + fmul_q;
                        r_lp1 <= r_lp; r_hp1 <= r_hp;
                        r_prev <= r_x;
                        r_step <= 4'd1; r_state <= svfl_pkg::ST_LP;
                    end else begin
                        r_bp <= r_bp + fmul_q;
                        r_step <= '0; r_state <= svfl_pkg::ST_OUT;
                    end
                end
                svfl_pkg::ST_OUT: begin
                    if (!r_ovalid) begin
                        r_low <= r_lp; r_band <= r_bp;
                        r_lo <= sat16(r_lp + r_lp1);
                        r_bo <= sat16(r_bp + r_bp1);
                        r_ho <= sat16(r_hp + r_hp1);
                        r_ovalid <= 1'b1;
                        if (r_mode) begin
                            pk = r_peak;
                            m = mag16(sat16(r_bp + r_bp1)); if (m > pk) pk = m;
                            m = mag16(sat16(r_lp + r_lp1)); if (m > pk) pk = m;
                            m = mag16(sat16(r_hp + r_hp1)); if (m > pk) pk = m;
                            r_peak <= pk;
                            if (r_win + 1'b1 >= svfl_pkg::WinEnd) begin
                                r_win <= '0;
                                r_state <= svfl_pkg::ST_ENV;
                                r_t <= 32'(({1'b0, pk, 16'd0} > {1'b0, r_env})
                                       ? ({pk, 16'd0} - {1'b0, r_env})
                                       : ({1'b0, r_env} - {pk, 16'd0}));
                                r_step <= ({pk, 16'd0} > {1'b0, r_env}) ? 4'd0 : 4'd1;
                            end else begin
                                r_win <= r_win + 1'b1;
                                r_state <= svfl_pkg::ST_IDLE;
                            end
                        end else begin
                            r_state <= svfl_pkg::ST_IDLE;
                        end
                    end
                end
                // attack/release update, then start gain division
                svfl_pkg::ST_ENV: begin
                    if (!r_step[3]) begin
                        r_prod <= mul_p; r_step <= r_step | 4'b1000;
                    end else begin
                        // a full-scale attack distance of 2^31 reads as negative
                        // in the signed multiplier; its scaled term is a shift
                        env_d = r_t[31] ? {1'b0, r_attack, 15'd0} : r_prod[47:16];
                        if (!r_step[0])
                            e = {1'b0, pk_full} - {1'b0, env_d};
                        else
                            e = {1'b0, pk_full} + {1'b0, env_d};
                        if (e > 33'h7FFFFFFF) e = 33'h7FFFFFFF;
                        r_env <= e[30:0];
                        r_peak <= '0;
                        if (e[30:0] > svfl_pkg::EnvThresh) begin
                            r_div <= e[30:16];
                            r_rem <= '0; r_quo <= svfl_pkg::GainNum;
                            r_dcnt <= 5'd23; r_state <= svfl_pkg::ST_DIV;
                        end else begin
                            r_gain <= svfl_pkg::UnityGain;
                            r_state <= svfl_pkg::ST_IDLE;
                        end
                    end
                end
                // restoring division, one quotient bit per cycle
                svfl_pkg::ST_DIV: begin
                    trial = {r_rem, r_quo[22]};
                    if (trial >= {9'd0, r_div}) begin
                        r_rem <= 23'(trial - {9'd0, r_div});
                        r_quo <= {r_quo[21:0], 1'b1};
                    end else begin
                        r_rem <= trial[22:0];
                        r_quo <= {r_quo[21:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) r_state <= svfl_pkg::ST_DONE;
                end
                svfl_pkg::ST_DONE: begin
                    r_gain <= r_quo[12:0];
                    r_state <= svfl_pkg::ST_IDLE;
                end
                default: r_state <= svfl_pkg::ST_IDLE;
            endcase
        end
    end

    // checks
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("sequencer state not one-hot");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != svfl_pkg::ST_IDLE))
        else $error("accepted sample left sequencer idle");
    a_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svfl_pkg::ST_DONE) |-> (r_quo[22:13] == '0))
        else $error("limiter gain overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_lo)))
        else $error("result dropped while stalled");

endmodule
